// ===== hw/rtl/cfsm_pkg.sv =====
// Shared types and constants for the circular FIFO with search and min/max.
// Used by the compare unit and the top level; no dependencies.
package cfsm_pkg;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_SCAN = 3'b100
	} state_t;

	typedef enum logic [2:0] {
		MODE_PUSH      = 3'd0,
		MODE_POP       = 3'd1,
		MODE_PEEK_HEAD = 3'd2,
		MODE_PEEK_TAIL = 3'd3,
		MODE_SEARCH    = 3'd4,
		MODE_MAX       = 3'd5,
		MODE_MIN       = 3'd6,
		MODE_CLEAR     = 3'd7
	} mode_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// -1.0 in Q16.16
	localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_0000;

	localparam int unsigned CAP_W    = 6;
	localparam int unsigned SLOT_W   = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 6'd20;

	typedef struct packed {
		logic first;
		logic is_max;
		logic is_min;
	} cmp_ctl_t;

endpackage

// ===== hw/rtl/cfsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== hw/rtl/cfsm_cmp.sv =====
// Shared compare unit: signed max/min selection and equality match on Q16.16.
// Depends on cfsm_pkg.
module cfsm_cmp
	import cfsm_pkg::*;
(
	input  cmp_ctl_t    ctl,
	input  logic [31:0] cand,
	input  logic [31:0] best,
	input  logic [31:0] key,
	output logic        take,
	output logic        match
);

	logic gt;
	logic lt;

	assign gt    = $signed(cand) > $signed(best);
	assign lt    = $signed(cand) < $signed(best);
	assign take  = ctl.first | (ctl.is_max & gt) | (ctl.is_min & lt);
	assign match = (cand == key);

endmodule

// ===== hw/rtl/circular_fifo_with_search_minmax.sv =====
// Circular FIFO of signed Q16.16 values with search, maximum and minimum.
// Depends on cfsm_pkg, cfsm_ram and cfsm_cmp.
//
// Usage:
//   Request channel: raise start with mode and operand while busy is low;
//   the request is taken at that clock edge and busy rises the next cycle.
//   Result channel: done pulses for one cycle with result_value, status,
//   found, found_slot, occupancy, is_full and is_empty. The receiver must
//   take it in that cycle; there is no backpressure.
//   Configuration: cfg_we with cfg_data writes capacity (0 acts as 1,
//   above DEPTH acts as DEPTH) and empties the queue. Write only when idle.
// Sequencing (request to done strobe):
//   push, clear, or any request on an empty queue: finished in S_EXEC.
//   pop, peek head, peek tail: S_EXEC, then S_SCAN (one slot read through the RAM).
//   search, max, min over n entries: S_EXEC, then S_SCAN; a search stops
//   at its first match. The single read port of the slot RAM and the one
//   compare unit step through one entry per cycle.
//   A new request may be taken in the cycle the done strobe is shown.
// Reset: head, tail and count clear, capacity returns to 20; slot contents
//   are left as they are and are never read before a push writes them.
module circular_fifo_with_search_minmax
	import cfsm_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         mode,
	input  logic signed [31:0] operand,
	input  logic               cfg_we,
	input  logic [CAP_W-1:0]   cfg_data,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic [1:0]         status,
	output logic               found,
	output logic [SLOT_W-1:0]  found_slot,
	output logic [CAP_W-1:0]   occupancy,
	output logic               is_full,
	output logic               is_empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;

	state_t            state_q;
	mode_t             mode_q;
	logic [31:0]       operand_q;
	logic [CAP_W-1:0]  cap_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic [EW-1:0]     count_q;
	logic [AW-1:0]     pos_q;
	logic [EW-1:0]     n_q;
	logic [EW-1:0]     issued_q;
	logic [EW-1:0]     cmp_cnt_q;
	logic [31:0]       best_q;
	logic              rd_vld_s1;
	logic [AW-1:0]     pos_s1;

	logic [EW-1:0]     cap_ext;
	logic [EW-1:0]     eff_cap;
	logic [AW-1:0]     tail_prev;
	logic              ram_we;
	logic [31:0]       rd_data;
	cmp_ctl_t          cmp_ctl;
	logic              take;
	logic              match;
	logic              last;
	logic              issue;

	logic              fin;
	logic [31:0]       fin_value;
	logic [1:0]        fin_status;
	logic              fin_found;
	logic [AW-1:0]     fin_slot;
	logic [EW-1:0]     cnt_after;

	function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx, input logic [EW-1:0] cap);
		logic [EW-1:0] n;
		n = EW'(idx) + EW'(1);
		return (n >= cap) ? '0 : AW'(n);
	endfunction

	assign cap_ext   = EW'(cap_q);
	assign eff_cap   = (cap_q == '0) ? EW'(1) :
	                   (cap_ext > EW'(DEPTH)) ? EW'(DEPTH) : cap_ext;
	assign tail_prev = (tail_q == '0) ? AW'(eff_cap - EW'(1)) : tail_q - AW'(1);
	assign busy      = (state_q != S_IDLE);

	assign ram_we = (state_q == S_EXEC) && (mode_q == MODE_PUSH) && (count_q < eff_cap);

	cfsm_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_slots (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(tail_q),
		.wr_data(operand_q),
		.rd_addr(pos_q),
		.rd_data(rd_data)
	);

	assign cmp_ctl.first  = (cmp_cnt_q == '0);
	assign cmp_ctl.is_max = (mode_q == MODE_MAX);
	assign cmp_ctl.is_min = (mode_q == MODE_MIN);

	cfsm_cmp u_cmp (
		.ctl  (cmp_ctl),
		.cand (rd_data),
		.best (best_q),
		.key  (operand_q),
		.take (take),
		.match(match)
	);

	assign last  = (cmp_cnt_q + EW'(1) == n_q);
	assign issue = (state_q == S_SCAN) && (issued_q < n_q) && !fin;

	// Result of the request that finishes this cycle
	always_comb begin
		fin        = 1'b0;
		fin_value  = '0;
		fin_status = ST_OK;
		fin_found  = 1'b0;
		fin_slot   = '0;
		cnt_after  = count_q;
		unique case (state_q)
			S_EXEC: begin
				case (mode_q) inside
					MODE_PUSH: begin
						fin = 1'b1;
						if (count_q >= eff_cap) begin
							fin_status = ST_FULL;
						end else begin
							cnt_after = count_q + EW'(1);
						end
					end
					MODE_CLEAR: begin
						fin       = 1'b1;
						cnt_after = '0;
					end
					MODE_SEARCH: begin
						fin = (count_q == '0);
					end
					default: begin
						if (count_q == '0) begin
							fin        = 1'b1;
							fin_value  = EMPTY_VALUE;
							fin_status = ST_EMPTY;
						end
					end
				endcase
			end
			S_SCAN: begin
				if (rd_vld_s1) begin
					if (mode_q == MODE_SEARCH) begin
						if (match) begin
							fin       = 1'b1;
							fin_found = 1'b1;
							fin_slot  = pos_s1;
						end else begin
							fin = last;
						end
					end else begin
						fin       = last;
						fin_value = take ? rd_data : best_q;
					end
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cap_q     <= CAP_RESET;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
			done      <= 1'b0;
		end else begin
			done      <= fin;
			rd_vld_s1 <= issue;
			if (cfg_we) begin
				cap_q   <= cfg_data;
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fin) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
					case (mode_q) inside
						MODE_PUSH: begin
							if (count_q < eff_cap) begin
								tail_q  <= adv(tail_q, eff_cap);
								count_q <= count_q + EW'(1);
							end
						end
						MODE_CLEAR: begin
							head_q  <= '0;
							tail_q  <= '0;
							count_q <= '0;
						end
						MODE_POP: begin
							if (count_q != '0) begin
								head_q  <= adv(head_q, eff_cap);
								count_q <= count_q - EW'(1);
							end
						end
						default: begin
						end
					endcase
				end
				S_SCAN: begin
					if (fin) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request, scan and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q    <= mode_t'(mode);
			operand_q <= operand;
		end
		if (state_q == S_EXEC) begin
			issued_q  <= '0;
			cmp_cnt_q <= '0;
			pos_q     <= (mode_q == MODE_PEEK_TAIL) ? tail_prev : head_q;
			n_q       <= (mode_q == MODE_SEARCH || mode_q == MODE_MAX ||
			              mode_q == MODE_MIN) ? count_q : EW'(1);
		end
		if (issue) begin
			pos_q    <= adv(pos_q, eff_cap);
			issued_q <= issued_q + EW'(1);
		end
		pos_s1 <= pos_q;
		if (rd_vld_s1) begin
			cmp_cnt_q <= cmp_cnt_q + EW'(1);
			if (take) begin
				best_q <= rd_data;
			end
		end
		if (fin) begin
			result_value <= fin_value;
			status       <= fin_status;
			found        <= fin_found;
			found_slot   <= SLOT_W'(fin_slot);
			occupancy    <= CAP_W'(cnt_after);
			is_full      <= (cnt_after == eff_cap);
			is_empty     <= (cnt_after == '0);
		end
	end

endmodule

// ===== bench/circular_fifo_with_search_minmax_tb.sv =====
// Self-checking bench for circular_fifo_with_search_minmax: queued requests, a shadow ring
// predicts every result, and results are checked field by field as done strobes.
// Depends on cfsm_pkg and the RTL top level only.
module circular_fifo_with_search_minmax_tb;
	import cfsm_pkg::*;

	localparam int unsigned RING_SLOTS  = 32;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SETTLE_CYC  = 40;

	typedef struct {
		mode_t              op;
		logic signed [31:0] operand;
	} fifo_req_t;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         status;
		logic               found;
		logic [SLOT_W-1:0]  slot;
		logic [CAP_W-1:0]   occ;
		logic               full;
		logic               empty;
	} fifo_res_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [2:0]         mode = MODE_PUSH;
	logic signed [31:0] operand = '0;
	logic               cfg_we = 1'b0;
	logic [CAP_W-1:0]   cfg_data = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] result_value;
	logic [1:0]         status;
	logic               found;
	logic [SLOT_W-1:0]  found_slot;
	logic [CAP_W-1:0]   occupancy;
	logic               is_full;
	logic               is_empty;

	circular_fifo_with_search_minmax #(.DEPTH(RING_SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.operand(operand),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.done(done),
		.result_value(result_value),
		.status(status),
		.found(found),
		.found_slot(found_slot),
		.occupancy(occupancy),
		.is_full(is_full),
		.is_empty(is_empty)
	);

	// shadow copy of the queue
	logic signed [31:0] shadow_slots [RING_SLOTS];
	int unsigned        shadow_head = 0;
	int unsigned        shadow_tail = 0;
	int unsigned        shadow_count = 0;
	logic [CAP_W-1:0]   shadow_cap = CAP_RESET;

	fifo_req_t          req_backlog [$];
	fifo_res_t          results_due [$];
	logic signed [31:0] pushed_history [$];
	int unsigned        idle_pct = 21;
	int unsigned        mismatches = 0;
	int unsigned        cycles = 0;
	bit                 req_taken = 1'b0;
	bit                 drain_hold = 1'b0;

	initial forever #5 clk = ~clk;

	function automatic int unsigned ring_next(int unsigned idx, int unsigned capn);
		return (idx + 1 >= capn) ? 0 : idx + 1;
	endfunction

	function automatic fifo_res_t fifo_apply(mode_t op, logic signed [31:0] val);
		fifo_res_t          r;
		int unsigned        capn;
		int unsigned        pos;
		logic signed [31:0] best;
		r = '{default: '0};
		capn = (shadow_cap == 0) ? 1 : (shadow_cap > RING_SLOTS) ? RING_SLOTS : shadow_cap;
		case (op)
			MODE_PUSH: begin
				if (shadow_count >= capn) begin
					r.status = ST_FULL;
				end else begin
					shadow_slots[shadow_tail] = val;
					shadow_tail = ring_next(shadow_tail, capn);
					shadow_count++;
				end
			end
			MODE_SEARCH: begin
				pos = shadow_head;
				for (int i = 0; i < shadow_count; i++) begin
					if (shadow_slots[pos] == val) begin
						r.found = 1'b1;
						r.slot = pos[SLOT_W-1:0];
						break;
					end
					pos = ring_next(pos, capn);
				end
			end
			MODE_CLEAR: begin
				shadow_head = 0;
				shadow_tail = 0;
				shadow_count = 0;
			end
			default: begin
				if (shadow_count == 0) begin
					r.value = EMPTY_VALUE;
					r.status = ST_EMPTY;
				end else if (op == MODE_POP) begin
					r.value = shadow_slots[shadow_head];
					shadow_head = ring_next(shadow_head, capn);
					shadow_count--;
				end else if (op == MODE_PEEK_HEAD) begin
					r.value = shadow_slots[shadow_head];
				end else if (op == MODE_PEEK_TAIL) begin
					r.value = shadow_slots[(shadow_tail == 0) ? capn - 1 : shadow_tail - 1];
				end else begin
					best = shadow_slots[shadow_head];
					pos = shadow_head;
					for (int i = 1; i < shadow_count; i++) begin
						pos = ring_next(pos, capn);
						if (op == MODE_MAX ? (shadow_slots[pos] > best) : (shadow_slots[pos] < best))
							best = shadow_slots[pos];
					end
					r.value = best;
				end
			end
		endcase
		r.occ = shadow_count[CAP_W-1:0];
		r.full = (shadow_count == capn);
		r.empty = (shadow_count == 0);
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// driver: present the next request at the falling edge, hold it until taken
	always @(negedge clk) begin : drv
		bit go;
		go = 1'b0;
		if (arst_n && (!start || req_taken)) begin
			req_taken = 1'b0;
			if (req_backlog.size() != 0) begin
				if (!drain_hold && $urandom_range(0, 99) < 2)
					drain_hold = 1'b1;
				if (drain_hold && results_due.size() == 0)
					drain_hold = 1'b0;
				go = !drain_hold && ($urandom_range(0, 99) >= idle_pct);
			end
			start <= go;
			if (go) begin
				mode <= req_backlog[0].op;
				operand <= req_backlog[0].operand;
			end
		end
	end

	// monitor: check the strobed result first, then record a newly taken request
	always @(posedge clk) begin : mon
		fifo_res_t want;
		if (arst_n) begin
			if (done) begin
				if (results_due.size() == 0) begin
					$error("result strobed with no request outstanding");
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("result_value", want.value, result_value);
					check_field("status", want.status, status);
					check_field("found", want.found, found);
					check_field("found_slot", want.slot, found_slot);
					check_field("occupancy", want.occ, occupancy);
					check_field("is_full", want.full, is_full);
					check_field("is_empty", want.empty, is_empty);
				end
			end
			if (start && !busy) begin
				results_due.push_back(fifo_apply(mode_t'(mode), operand));
				void'(req_backlog.pop_front());
				req_taken = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic add_req(mode_t op, logic signed [31:0] val);
		req_backlog.push_back('{op: op, operand: val});
	endtask

	task automatic wait_idle();
		while (req_backlog.size() != 0 || results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		wait_idle();
		repeat (2) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= cap;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow_cap = cap;
		shadow_head = 0;
		shadow_tail = 0;
		shadow_count = 0;
	endtask

	function automatic logic signed [31:0] pick_operand();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return EMPTY_VALUE;
			3: return '0;
			4, 5: return (32'($urandom_range(0, 15)) - 32'd8) << 16;
			default: return $urandom();
		endcase
	endfunction

	// alternate fill and drain bursts so the ring wraps and reaches full and empty
	task automatic queue_random(int unsigned n);
		int unsigned        r;
		int unsigned        run;
		bit                 filling;
		mode_t              op;
		logic signed [31:0] val;
		filling = 1'b0;
		run = 0;
		for (int k = 0; k < n; k++) begin
			if (run == 0) begin
				filling = ~filling;
				run = filling ? $urandom_range(8, 60) : $urandom_range(4, 40);
			end
			run--;
			r = $urandom_range(0, 99);
			if (filling)
				op = (r < 60) ? MODE_PUSH : (r < 68) ? MODE_POP : (r < 74) ? MODE_PEEK_HEAD :
					(r < 80) ? MODE_PEEK_TAIL : (r < 88) ? MODE_SEARCH : (r < 93) ? MODE_MAX :
					(r < 99) ? MODE_MIN : MODE_CLEAR;
			else
				op = (r < 10) ? MODE_PUSH : (r < 55) ? MODE_POP : (r < 63) ? MODE_PEEK_HEAD :
					(r < 70) ? MODE_PEEK_TAIL : (r < 82) ? MODE_SEARCH : (r < 89) ? MODE_MAX :
					(r < 97) ? MODE_MIN : MODE_CLEAR;
			val = pick_operand();
			if (op == MODE_SEARCH && pushed_history.size() != 0 && $urandom_range(0, 9) < 7)
				val = pushed_history[$urandom_range(0, pushed_history.size() - 1)];
			if (op == MODE_PUSH) begin
				pushed_history.push_back(val);
				if (pushed_history.size() > 16)
					void'(pushed_history.pop_front());
			end
			add_req(op, val);
		end
	endtask

	initial begin
		logic [CAP_W-1:0] caps [8];
		int unsigned      sizes [8];
		caps = '{6'd2, 6'd63, 6'd5, 6'd32, 6'd33, 6'd1, CAP_W'($urandom_range(3, 31)), 6'd20};
		sizes = '{40, 70, 40, 70, 40, 30, 50, 60};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset capacity: every reading request on an empty queue, then mixed signs and extremes
		add_req(MODE_POP, '0);
		add_req(MODE_PEEK_HEAD, '0);
		add_req(MODE_PEEK_TAIL, '0);
		add_req(MODE_MAX, '0);
		add_req(MODE_MIN, '0);
		add_req(MODE_SEARCH, '0);
		add_req(MODE_PUSH, 32'sh7FFF_FFFF);
		add_req(MODE_PUSH, 32'sh8000_0000);
		add_req(MODE_PUSH, EMPTY_VALUE);
		add_req(MODE_PUSH, '0);
		add_req(MODE_PUSH, 32'sh0001_0000);
		add_req(MODE_SEARCH, 32'sh8000_0000);
		add_req(MODE_SEARCH, EMPTY_VALUE);
		add_req(MODE_SEARCH, 32'sh0001_2345);
		add_req(MODE_MAX, '0);
		add_req(MODE_MIN, '0);
		add_req(MODE_PEEK_HEAD, '0);
		add_req(MODE_PEEK_TAIL, '0);
		add_req(MODE_POP, '0);
		add_req(MODE_CLEAR, '0);

		// zero capacity acts as one slot: second push is dropped
		write_capacity('0);
		add_req(MODE_PUSH, 32'sh0000_0001);
		add_req(MODE_PUSH, 32'sh0000_0002);
		add_req(MODE_PEEK_TAIL, '0);
		add_req(MODE_MAX, '0);
		add_req(MODE_POP, '0);
		add_req(MODE_POP, '0);

		for (int p = 0; p < 8; p++) begin
			write_capacity(caps[p]);
			idle_pct = (p < 3) ? 21 : (p < 6) ? 49 : 0;
			queue_random(sizes[p]);
		end

		wait_idle();
		repeat (SETTLE_CYC) @(posedge clk);
		if (results_due.size() != 0) begin
			$error("%0d results never arrived", results_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== circular_fifo_with_search_minmax.f =====
hw/rtl/cfsm_pkg.sv
hw/rtl/cfsm_ram.sv
hw/rtl/cfsm_cmp.sv
hw/rtl/circular_fifo_with_search_minmax.sv
bench/circular_fifo_with_search_minmax_tb.sv
